// ----- src/wtc_pkg.sv -----
// Package for the word token classifier: token and automaton codes, the
// reserved word table and the character class functions.
// No dependencies; every other source file imports it.
package wtc_pkg;

  // Token codes carried on the result channel.
  typedef enum logic [3:0] {
    TOK_WORD1       = 4'd0,
    TOK_WORD2       = 4'd1,
    TOK_PERIOD      = 4'd2,
    TOK_ERROR       = 4'd3,
    TOK_EOFM        = 4'd4,
    TOK_VERB        = 4'd5,
    TOK_VERBNEG     = 4'd6,
    TOK_VERBPAST    = 4'd7,
    TOK_VERBPASTNEG = 4'd8,
    TOK_IS          = 4'd9,
    TOK_WAS         = 4'd10,
    TOK_OBJECT      = 4'd11,
    TOK_SUBJECT     = 4'd12,
    TOK_DESTINATION = 4'd13,
    TOK_PRONOUN     = 4'd14,
    TOK_CONNECTOR   = 4'd15
  } token_t;

  // Syllable automaton states; DFA_ERR is sticky until the word ends.
  typedef enum logic [3:0] {
    DFA_S0  = 4'd0,
    DFA_S1  = 4'd1,
    DFA_S2  = 4'd2,
    DFA_S3  = 4'd3,
    DFA_S4  = 4'd4,
    DFA_S5  = 4'd5,
    DFA_S6  = 4'd6,
    DFA_S7  = 4'd7,
    DFA_ERR = 4'd8
  } dfa_state_t;

  // One character step handed to the scanner.
  typedef struct packed {
    logic       go;
    logic       last;
    logic [7:0] ch;
  } step_t;

  // Result produced by the scanner for the current step.
  typedef struct packed {
    token_t tok;
    logic   is_err;
  } result_t;

  localparam int NUM_KW  = 20;
  localparam int KW_MAXW = 12;
  localparam int KW_BITS = KW_MAXW * 8;

  localparam logic [3:0] LEN_MAX = 4'd15;

  // Reserved words, right justified: the last character sits in bits [7:0].
  localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KW] = '{
    "masu", "masen", "mashita", "masendeshita", "desu", "deshita",
    "o", "wa", "ni", "watashi", "anata", "kare", "kanojo", "sore",
    "mata", "soshite", "shikashi", "dakara", "eofm", "EOFM"
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd4, 4'd5, 4'd7, 4'd12, 4'd4, 4'd7, 4'd1, 4'd2, 4'd2, 4'd7,
    4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd7, 4'd8, 4'd6, 4'd4, 4'd4
  };

  localparam token_t KW_TOK [NUM_KW] = '{
    TOK_VERB, TOK_VERBNEG, TOK_VERBPAST, TOK_VERBPASTNEG, TOK_IS, TOK_WAS,
    TOK_OBJECT, TOK_SUBJECT, TOK_DESTINATION, TOK_PRONOUN, TOK_PRONOUN,
    TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN, TOK_CONNECTOR, TOK_CONNECTOR,
    TOK_CONNECTOR, TOK_CONNECTOR, TOK_EOFM, TOK_EOFM
  };

  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_N_LO   = 8'h6E;
  localparam logic [7:0] CH_C_LO   = 8'h63;
  localparam logic [7:0] CH_S_LO   = 8'h73;
  localparam logic [7:0] CH_T_LO   = 8'h74;
  localparam logic [7:0] CH_H_LO   = 8'h68;
  localparam logic [7:0] CH_Y_LO   = 8'h79;
  localparam logic [7:0] CH_I_UP   = 8'h49;
  localparam logic [7:0] CH_E_UP   = 8'h45;

  function automatic logic is_vowel(logic [7:0] c);
    return c == "a" || c == "e" || c == "i" || c == "o" || c == "u" ||
           c == CH_E_UP || c == CH_I_UP;
  endfunction

  function automatic logic is_cons_start(logic [7:0] c);
    return c == "b" || c == "g" || c == CH_H_LO || c == "k" || c == "m" ||
           c == CH_N_LO || c == "p" || c == "r";
  endfunction

  function automatic logic is_cons_end(logic [7:0] c);
    return c == "d" || c == "w" || c == "z" || c == CH_Y_LO || c == "j";
  endfunction

  // True when reserved word k still matches with character c at position pos.
  function automatic logic kw_keep(int k, logic [3:0] pos, logic [7:0] c);
    logic [3:0]         len;
    logic [3:0]         sel;
    logic [KW_BITS-1:0] txt;
    len = KW_LEN[k];
    txt = KW_TEXT[k];
    sel = len - 4'd1 - pos;
    return (pos < len) && (txt[{sel, 3'b000} +: 8] == c);
  endfunction

endpackage

// ----- src/word_token_classifier_unit.sv -----
// Top level of the word token classifier: input register, scanner and
// result register with valid/ready handshakes on both sides.
// Depends on wtc_pkg and wtc_scan.
//
// Usage: each input transaction carries one character of a word (in_ch)
// and in_word_end, set on the word's last character. Characters produce no
// result; the last character of each word produces exactly one result
// transaction with the token code (out_token_type) and out_is_error.
// The result of a word passes from the input register through the scanner
// into the result register once that register is free, and is offered on out_valid.
// Throughput: one character per cycle, sustained, as long as results are
// taken when offered. The scanner updates its per-word state from the input
// register as each character moves on, so words may follow back to back.
// Stall: while a result waits in the output register, characters keep
// flowing; only a second last-of-word character stops in the input register
// and drops in_ready until the waiting result is taken.
// Reset: rst_n low for one clock empties both registers and returns all
// per-word state to the start of a word.
module word_token_classifier_unit
  import wtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_word_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_token_type,
  output logic       out_is_error
);

  logic       s1_vld_r;
  logic       s1_vld_nxt;
  logic [7:0] s1_ch_r;
  logic       s1_end_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  token_t     out_tok_r;
  logic       out_err_r;
  logic       in_fire;
  logic       out_free;
  logic       s1_go;
  step_t      step;
  result_t    result;

  // Handshake: a staged character moves on unless it ends a word and the
  // output register is still occupied.
  assign out_free = !out_vld_r || out_ready;
  assign s1_go    = s1_vld_r && (!s1_end_r || out_free);
  assign in_ready = !s1_vld_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_go && s1_end_r) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  assign step.go   = s1_go;
  assign step.last = s1_end_r;
  assign step.ch   = s1_ch_r;

  wtc_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .result (result)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r  <= in_ch;
      s1_end_r <= in_word_end;
    end
    if (s1_go && s1_end_r) begin
      out_tok_r <= result.tok;
      out_err_r <= result.is_err;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_token_type = out_tok_r;
  assign out_is_error   = out_err_r;

endmodule

// ----- src/wtc_dfa.sv -----
// Syllable automaton of the word token classifier: state register,
// next-state logic and the accepting-state flag.
// Depends on wtc_pkg.
module wtc_dfa
  import wtc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  step_t step,
  output logic  accept
);

  dfa_state_t state_r;
  dfa_state_t state_upd;
  dfa_state_t state_nxt;
  logic [7:0] c;

  assign c = step.ch;

  // Transition for the incoming character.
  always_comb begin
    state_upd = DFA_ERR;
    unique case (state_r)
      DFA_S0: begin
        priority if (is_cons_start(c)) state_upd = DFA_S6;
        else if (is_cons_end(c))       state_upd = DFA_S5;
        else if (c == CH_S_LO)         state_upd = DFA_S4;
        else if (c == CH_T_LO)         state_upd = DFA_S2;
        else if (is_vowel(c))          state_upd = DFA_S1;
        else                           state_upd = DFA_ERR;
      end
      DFA_S1: begin
        priority if (is_vowel(c))      state_upd = DFA_S1;
        else if (c == CH_N_LO)         state_upd = DFA_S3;
        else if (is_cons_end(c))       state_upd = DFA_S5;
        else if (is_cons_start(c))     state_upd = DFA_S6;
        else if (c == CH_S_LO)         state_upd = DFA_S4;
        else if (c == CH_T_LO)         state_upd = DFA_S2;
        else                           state_upd = DFA_ERR;
      end
      DFA_S2: begin
        priority if (is_vowel(c))      state_upd = DFA_S1;
        else if (c == CH_S_LO)         state_upd = DFA_S5;
        else                           state_upd = DFA_ERR;
      end
      DFA_S3: begin
        priority if (is_vowel(c))      state_upd = DFA_S1;
        else if (c == CH_T_LO)         state_upd = DFA_S2;
        else if (c == CH_S_LO)         state_upd = DFA_S4;
        else if (c == CH_C_LO)         state_upd = DFA_S7;
        else if (is_cons_start(c))     state_upd = DFA_S6;
        else if (is_cons_end(c))       state_upd = DFA_S5;
        else                           state_upd = DFA_ERR;
      end
      DFA_S4: begin
        priority if (is_vowel(c))      state_upd = DFA_S1;
        else if (c == CH_H_LO)         state_upd = DFA_S5;
        else                           state_upd = DFA_ERR;
      end
      DFA_S5: begin
        if (is_vowel(c)) state_upd = DFA_S1;
        else             state_upd = DFA_ERR;
      end
      DFA_S6: begin
        priority if (is_vowel(c))      state_upd = DFA_S1;
        else if (c == CH_Y_LO)         state_upd = DFA_S5;
        else                           state_upd = DFA_ERR;
      end
      DFA_S7: begin
        if (c == CH_H_LO) state_upd = DFA_S5;
        else              state_upd = DFA_ERR;
      end
      default: state_upd = DFA_ERR;
    endcase
  end

  // Advance on each step; the word's last character returns to the start.
  always_comb begin
    state_nxt = state_r;
    if (step.go) begin
      state_nxt = step.last ? DFA_S0 : state_upd;
    end
  end

  // The word is well formed when it ends in one of the accepting states.
  always_comb begin
    accept = (state_upd == DFA_S0) || (state_upd == DFA_S1) ||
             (state_upd == DFA_S3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DFA_S0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/wtc_scan.sv -----
// Per-word scanner: keyword candidate mask, length count, period check,
// last two characters and the token decision for a word's last character.
// Depends on wtc_pkg and wtc_dfa.
module wtc_scan
  import wtc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  step_t   step,
  output result_t result
);

  logic [NUM_KW-1:0] hits_r;
  logic [NUM_KW-1:0] hits_nxt;
  logic [NUM_KW-1:0] hits_upd;
  logic [3:0]        len_r;
  logic [3:0]        len_nxt;
  logic [3:0]        len_upd;
  logic              period_r;
  logic              period_nxt;
  logic              period_upd;
  logic [7:0]        last_r;
  logic [7:0]        last_nxt;
  logic              accept;
  logic              eofm_hit;
  logic              kw_hit;
  token_t            kw_tok;
  token_t            tok;

  wtc_dfa u_dfa (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .accept (accept)
  );

  // Candidate mask, length and period check after this character.
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      hits_upd[k] = hits_r[k] && kw_keep(k, len_r, step.ch);
    end
    len_upd    = (len_r < LEN_MAX) ? len_r + 4'd1 : LEN_MAX;
    period_upd = period_r && (len_r == 4'd0) && (step.ch == CH_PERIOD);
  end

  // Per-word state returns to reset after the word's last character.
  always_comb begin
    hits_nxt   = hits_r;
    len_nxt    = len_r;
    period_nxt = period_r;
    last_nxt   = last_r;
    if (step.go) begin
      if (step.last) begin
        hits_nxt   = '1;
        len_nxt    = 4'd0;
        period_nxt = 1'b1;
        last_nxt   = 8'd0;
      end else begin
        hits_nxt   = hits_upd;
        len_nxt    = len_upd;
        period_nxt = period_upd;
        last_nxt   = step.ch;
      end
    end
  end

  // Reserved word lookup on the full-length candidates.
  always_comb begin
    eofm_hit = 1'b0;
    kw_hit   = 1'b0;
    kw_tok   = TOK_WORD1;
    for (int k = 0; k < NUM_KW; k++) begin
      if (hits_upd[k] && (KW_LEN[k] == len_upd)) begin
        if (KW_TOK[k] == TOK_EOFM) begin
          eofm_hit = 1'b1;
        end else begin
          kw_hit = 1'b1;
          kw_tok = KW_TOK[k];
        end
      end
    end
  end

  // Token decision: end marker, period, then the automaton, reserved words and word ending.
  always_comb begin
    priority if (eofm_hit) begin
      tok = TOK_EOFM;
    end else if (period_upd) begin
      tok = TOK_PERIOD;
    end else if (!accept) begin
      tok = TOK_ERROR;
    end else if (kw_hit) begin
      tok = kw_tok;
    end else if (step.ch == CH_I_UP || step.ch == CH_E_UP) begin
      tok = TOK_WORD2;
    end else if (is_vowel(step.ch) || (is_vowel(last_r) && step.ch == CH_N_LO)) begin
      tok = TOK_WORD1;
    end else begin
      tok = TOK_ERROR;
    end
  end

  assign result.tok    = tok;
  assign result.is_err = (tok == TOK_ERROR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '1;
      len_r    <= 4'd0;
      period_r <= 1'b1;
      last_r   <= 8'd0;
    end else begin
      hits_r   <= hits_nxt;
      len_r    <= len_nxt;
      period_r <= period_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule

// ----- src/wtc_checker.sv -----
// Port-level checker for the word token classifier, bound to the top level.
// Depends on wtc_pkg and word_token_classifier_unit.
module wtc_checker
  import wtc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_token_type,
  input logic       out_is_error
);

  // While a result is offered, the error flag agrees with the token code.
  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_error == (out_token_type == TOK_ERROR)))
    else $error("out_is_error disagrees with out_token_type");

  // Input stalls only behind a result that the receiver is holding off.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  // Reset leaves no result on offer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result stays offered and holds its token code.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_token_type)))
    else $error("stalled result changed or dropped");

endmodule

bind word_token_classifier_unit wtc_checker u_wtc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_token_type (out_token_type),
  .out_is_error   (out_is_error)
);

// ----- bench/wtc_token_checker.sv -----
// Checker for the word token classifier: watches both channels, predicts the
// token of every word from the accepted characters and compares the results.
// Depends on wtc_pkg for the token and automaton state codes.
module wtc_token_checker
  import wtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_word_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_token_type,
  input  logic       out_is_error,
  output int         mismatch_count,
  output int         words_in_flight
);

  localparam int NUM_RESERVED   = 20;
  localparam int FIRST_END_MARK = 18;
  localparam int SHOWN_ERRORS   = 10;
  localparam logic [3:0] LEN_CAP = 4'd15;

  // Reserved words and their classes; the last two are the end-of-file marks.
  string reserved_text [NUM_RESERVED] = '{
    "masu", "masen", "mashita", "masendeshita", "desu", "deshita",
    "o", "wa", "ni", "watashi", "anata", "kare", "kanojo", "sore",
    "mata", "soshite", "shikashi", "dakara", "eofm", "EOFM"
  };
  token_t reserved_class [NUM_RESERVED] = '{
    TOK_VERB, TOK_VERBNEG, TOK_VERBPAST, TOK_VERBPASTNEG, TOK_IS, TOK_WAS,
    TOK_OBJECT, TOK_SUBJECT, TOK_DESTINATION, TOK_PRONOUN, TOK_PRONOUN,
    TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN, TOK_CONNECTOR, TOK_CONNECTOR,
    TOK_CONNECTOR, TOK_CONNECTOR, TOK_EOFM, TOK_EOFM
  };

  // Per-word prediction state.
  dfa_state_t                syl_state;
  logic [3:0]                word_len;
  logic [NUM_RESERVED-1:0]   word_candidates;
  logic                      only_period;
  logic [7:0]                cur_ch;
  logic [7:0]                prior_ch;

  // Tokens predicted for words whose result has not yet been taken.
  token_t expected_tokens[$];

  initial begin
    mismatch_count = 0;
  end

  function automatic bit vowel_ch(logic [7:0] c);
    case (c)
      "a", "e", "i", "o", "u", "E", "I": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit onset_ch(logic [7:0] c);
    case (c)
      "b", "g", "h", "k", "m", "n", "p", "r": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit coda_ch(logic [7:0] c);
    case (c)
      "d", "w", "z", "y", "j": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // One step of the syllable automaton; the error state never leaves.
  function automatic dfa_state_t syllable_next(dfa_state_t s, logic [7:0] c);
    case (s)
      DFA_S0: begin
        if (onset_ch(c)) return DFA_S6;
        if (coda_ch(c)) return DFA_S5;
        if (c == "s") return DFA_S4;
        if (c == "t") return DFA_S2;
        if (vowel_ch(c)) return DFA_S1;
      end
      DFA_S1: begin
        if (vowel_ch(c)) return DFA_S1;
        if (c == "n") return DFA_S3;
        if (coda_ch(c)) return DFA_S5;
        if (onset_ch(c)) return DFA_S6;
        if (c == "s") return DFA_S4;
        if (c == "t") return DFA_S2;
      end
      DFA_S2: begin
        if (vowel_ch(c)) return DFA_S1;
        if (c == "s") return DFA_S5;
      end
      DFA_S3: begin
        if (vowel_ch(c)) return DFA_S1;
        if (c == "t") return DFA_S2;
        if (c == "s") return DFA_S4;
        if (c == "c") return DFA_S7;
        if (onset_ch(c)) return DFA_S6;
        if (coda_ch(c)) return DFA_S5;
      end
      DFA_S4: begin
        if (vowel_ch(c)) return DFA_S1;
        if (c == "h") return DFA_S5;
      end
      DFA_S5: begin
        if (vowel_ch(c)) return DFA_S1;
      end
      DFA_S6: begin
        if (vowel_ch(c)) return DFA_S1;
        if (c == "y") return DFA_S5;
      end
      DFA_S7: begin
        if (c == "h") return DFA_S5;
      end
      default: ;
    endcase
    return DFA_ERR;
  endfunction

  // Token of the word held in the per-word state.
  function automatic token_t word_token();
    token_t kw_tok;
    bit     kw_found;
    kw_tok   = TOK_WORD1;
    kw_found = 1'b0;
    for (int k = 0; k < NUM_RESERVED; k++) begin
      if (word_candidates[k] && reserved_text[k].len() == int'(word_len)) begin
        if (k >= FIRST_END_MARK) return TOK_EOFM;
        kw_tok   = reserved_class[k];
        kw_found = 1'b1;
      end
    end
    if (only_period) return TOK_PERIOD;
    if (syl_state == DFA_S0 || syl_state == DFA_S1 || syl_state == DFA_S3) begin
      if (kw_found) return kw_tok;
      if (cur_ch == "I" || cur_ch == "E") return TOK_WORD2;
      if (vowel_ch(cur_ch) || (vowel_ch(prior_ch) && cur_ch == "n")) return TOK_WORD1;
    end
    return TOK_ERROR;
  endfunction

  task automatic clear_word();
    syl_state       = DFA_S0;
    word_len        = '0;
    word_candidates = '1;
    only_period     = 1'b1;
    cur_ch          = '0;
    prior_ch        = '0;
  endtask

  // Fold one accepted character into the word; the last one yields a token.
  task automatic absorb_char(logic [7:0] c, logic last);
    logic [3:0] pos;
    pos = word_len;
    only_period = only_period && (pos == 4'd0) && (c == ".");
    for (int k = 0; k < NUM_RESERVED; k++) begin
      if (!(int'(pos) < reserved_text[k].len() && reserved_text[k][pos] == c))
        word_candidates[k] = 1'b0;
    end
    syl_state = syllable_next(syl_state, c);
    prior_ch  = cur_ch;
    cur_ch    = c;
    word_len  = (pos < LEN_CAP) ? pos + 4'd1 : LEN_CAP;
    if (last) begin
      expected_tokens.push_back(word_token());
      clear_word();
    end
  endtask

  // Compare a result transaction with the oldest predicted token.
  task automatic check_result();
    token_t want;
    logic   want_err;
    if (expected_tokens.size() == 0) begin
      if (mismatch_count < SHOWN_ERRORS)
        $display("checker: unexpected result token=%0d is_error=%0b",
                 out_token_type, out_is_error);
      mismatch_count++;
      return;
    end
    want     = expected_tokens.pop_front();
    want_err = (want == TOK_ERROR);
    if (out_token_type !== want || out_is_error !== want_err) begin
      if (mismatch_count < SHOWN_ERRORS)
        $display("checker: token mismatch expected %0d/%0b got %0d/%0b",
                 want, want_err, out_token_type, out_is_error);
      mismatch_count++;
    end
  endtask

  // Results are checked before the same edge's character is folded in.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_word();
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) absorb_char(in_ch, in_word_end);
    end
    words_in_flight <= expected_tokens.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the word token classifier bench: clock, reset, word stimulus and
// random flow control, with the verdict taken from the checker.
// Depends on wtc_pkg, word_token_classifier_unit and wtc_token_checker.
module testbench
  import wtc_pkg::*;
();

  localparam int RANDOM_CHARS = 1350;
  localparam int NUM_PHASES   = 3;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = '0;
  logic       in_word_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_token_type;
  logic       out_is_error;

  int mismatch_count;
  int words_in_flight;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int chars_sent = 0;

  logic [7:0] spell_buf[$];

  string reserved_words [20] = '{
    "masu", "masen", "mashita", "masendeshita", "desu", "deshita",
    "o", "wa", "ni", "watashi", "anata", "kare", "kanojo", "sore",
    "mata", "soshite", "shikashi", "dakara", "eofm", "EOFM"
  };
  string syllables [35] = '{
    "a", "i", "u", "e", "o", "ka", "ki", "ku", "ke", "ko", "shi", "su",
    "so", "ta", "te", "to", "tsu", "ya", "yo", "kyo", "ryu", "wa", "de",
    "jo", "ba", "n", "mi", "ne", "ho", "ge", "pi", "zu", "nchi", "E", "I"
  };
  string period_words [5] = '{".", "..", ".a", "a.", ".n"};
  string letters = "aeiouIEnbcdghjkmprstwyz.";

  word_token_classifier_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_word_end    (in_word_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_type (out_token_type),
    .out_is_error   (out_is_error)
  );

  wtc_token_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_word_end     (in_word_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_type  (out_token_type),
    .out_is_error    (out_is_error),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // The result side stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= out_idle_pct);
  end

  function automatic logic [7:0] random_letter();
    return letters[$urandom_range(0, letters.len() - 1)];
  endfunction

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) spell_buf.push_back(s[i]);
  endtask

  task automatic append_syllables(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) append_text(syllables[$urandom_range(0, 34)]);
  endtask

  // One character transaction, with random idle cycles ahead of it.
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_ch       <= c;
    in_word_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  // Sends the word held in spell_buf, flagging its last character.
  task automatic send_spelling();
    for (int i = 0; i < spell_buf.size(); i++)
      send_char(spell_buf[i], i == spell_buf.size() - 1);
    spell_buf.delete();
  endtask

  task automatic send_text(string s);
    append_text(s);
    send_spelling();
  endtask

  // Mostly well-formed words and reserved words, the rest noise.
  task automatic build_random_word();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      append_text(reserved_words[$urandom_range(0, 19)]);
    end else if (pick < 32) begin
      // Near misses of a reserved word.
      append_text(reserved_words[$urandom_range(0, 19)]);
      case ($urandom_range(0, 2))
        0: spell_buf[$urandom_range(0, spell_buf.size() - 1)] = random_letter();
        1: spell_buf.push_back(random_letter());
        default: if (spell_buf.size() > 1) void'(spell_buf.pop_back());
      endcase
    end else if (pick < 67) begin
      append_syllables(1, 4);
    end else if (pick < 72) begin
      append_syllables(8, 12);
    end else if (pick < 77) begin
      append_text(period_words[$urandom_range(0, 4)]);
    end else if (pick < 90) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) spell_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) spell_buf.push_back(random_letter());
    end
  endtask

  initial begin
    int phase_end;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: period, shortest, end-of-file and verb reserved words,
    // vowel plus n, WORD2 ending, ill-formed word, bytes 00 and FF, length at cap.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_text(".");
    send_text("o");
    send_text("EOFM");
    send_text("an");
    send_text("E");
    send_text("masu");
    send_text("sh");
    spell_buf.push_back(8'h00);
    send_spelling();
    spell_buf.push_back(8'hFF);
    send_spelling();
    send_text("kakikukekotsuna");

    // Random words in three flow-control phases.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin in_idle_pct = 34; out_idle_pct = 85; end
        1: begin in_idle_pct = 85; out_idle_pct = 34; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      phase_end = chars_sent + RANDOM_CHARS / NUM_PHASES;
      while (chars_sent < phase_end) begin
        build_random_word();
        send_spelling();
      end
    end
    in_valid <= 1'b0;

    // Drain the outstanding results.
    do @(posedge clk); while (words_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- word_token_classifier_unit.f -----
src/wtc_pkg.sv
src/wtc_dfa.sv
src/wtc_scan.sv
src/word_token_classifier_unit.sv
src/wtc_checker.sv
bench/wtc_token_checker.sv
bench/testbench.sv
